// ===== rtl/core/weighted_depth_imbalance_defines.svh =====
// Assertion macros for the weighted depth imbalance block.
// Each use expands to one labeled concurrent assertion on clk_i.
`ifndef WEIGHTED_DEPTH_IMBALANCE_DEFINES_SVH
`define WEIGHTED_DEPTH_IMBALANCE_DEFINES_SVH

// Checked only while the block is out of reset.
`define WDI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define WDI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/wdi_pkg.sv =====
// ----------------------------------------------------------------------------
// wdi_pkg
// Shared widths, constants and types of the weighted depth imbalance block.
// ----------------------------------------------------------------------------
package wdi_pkg;

  localparam int VolW     = 32;  // queue volume
  localparam int WeightW  = 17;  // Q1.16 level weight
  localparam int MaskW    = 5;   // level presence mask
  localparam int NumSlots = 5;   // book levels carried by a word
  localparam int FracBits = 14;  // fraction bits of the result
  localparam int ImbW     = 16;  // Q2.14 result
  localparam int OneQ14   = 16384;

  localparam int LevelsDefault = 5;

  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  localparam logic [WeightW-1:0] WeightReset [NumSlots] = '{
    17'd65536, 17'd39750, 17'd24110, 17'd14623, 17'd8869
  };

  // Control bits that travel beside the quotient data.
  typedef struct packed {
    logic ok;        // book two-sided and weighted depth nonzero
    logic negative;  // ask side outweighs bid side
  } wdi_ctl_t;

endpackage

// ===== rtl/core/wdi_if.sv =====
// ----------------------------------------------------------------------------
// wdi_in_if / wdi_out_if
// Valid/ready channels that carry book snapshot words and result words.
// ----------------------------------------------------------------------------
interface wdi_in_if;
  import wdi_pkg::*;

  logic             valid;
  logic             ready;
  logic [VolW-1:0]  bid_volume_0;
  logic [VolW-1:0]  bid_volume_1;
  logic [VolW-1:0]  bid_volume_2;
  logic [VolW-1:0]  bid_volume_3;
  logic [VolW-1:0]  bid_volume_4;
  logic [VolW-1:0]  ask_volume_0;
  logic [VolW-1:0]  ask_volume_1;
  logic [VolW-1:0]  ask_volume_2;
  logic [VolW-1:0]  ask_volume_3;
  logic [VolW-1:0]  ask_volume_4;
  logic [MaskW-1:0] bid_present_mask;
  logic [MaskW-1:0] ask_present_mask;

  modport source (
    output valid, bid_volume_0, bid_volume_1, bid_volume_2, bid_volume_3,
           bid_volume_4, ask_volume_0, ask_volume_1, ask_volume_2,
           ask_volume_3, ask_volume_4, bid_present_mask, ask_present_mask,
    input  ready
  );

  modport sink (
    input  valid, bid_volume_0, bid_volume_1, bid_volume_2, bid_volume_3,
           bid_volume_4, ask_volume_0, ask_volume_1, ask_volume_2,
           ask_volume_3, ask_volume_4, bid_present_mask, ask_present_mask,
    output ready
  );
endinterface

interface wdi_out_if;
  import wdi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   result_valid;
  logic signed [ImbW-1:0] imbalance;

  modport source (output valid, result_valid, imbalance, input ready);
  modport sink   (input valid, result_valid, imbalance, output ready);
endinterface

// ===== rtl/core/wdi_div_pipe.sv =====
// ----------------------------------------------------------------------------
// wdi_div_pipe
// Pipelined restoring divider: one quotient bit per stage, then sign and
// saturation into a Q2.14 output register.
// ----------------------------------------------------------------------------
module wdi_div_pipe #(
  parameter int DenW = 53
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [DenW-1:0]                 mag_i,
  input  logic [DenW-1:0]                 den_i,
  input  wdi_pkg::wdi_ctl_t               ctl_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_valid_o,
  output logic signed [wdi_pkg::ImbW-1:0] imbalance_o
);
  import wdi_pkg::*;

  localparam int RemW  = DenW + 1;
  localparam int QW    = FracBits + 1;
  localparam int Steps = QW;

  logic [RemW-1:0] rem_q [Steps];
  logic [DenW-1:0] den_q [Steps];
  logic [QW-1:0]   quo_q [Steps];
  wdi_ctl_t        ctl_q [Steps];
  logic [Steps-1:0] v_q;
  logic [Steps:0]   en;

  logic                   ov_q;
  logic                   res_valid_q;
  logic signed [ImbW-1:0] imb_q;

  // A stage moves when it is empty or the one after it moves.
  assign en[Steps] = ~ov_q | out_ready_i;

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [RemW-1:0] rem_s;
    logic [QW-1:0]   quo_s;
    logic [DenW-1:0] den_s;
    wdi_ctl_t        ctl_s;
    logic            vin;
    logic            ge;
    logic [RemW-1:0] rem_n;

    assign en[j] = ~v_q[j] | en[j+1];

    if (j == 0) begin : g_first
      assign rem_s = RemW'(mag_i);
      assign quo_s = '0;
      assign den_s = den_i;
      assign ctl_s = ctl_i;
      assign vin   = in_valid_i;
    end else begin : g_next
      assign rem_s = {rem_q[j-1][RemW-2:0], 1'b0};
      assign quo_s = {quo_q[j-1][QW-2:0], 1'b0};
      assign den_s = den_q[j-1];
      assign ctl_s = ctl_q[j-1];
      assign vin   = v_q[j-1];
    end

    assign ge    = rem_s >= RemW'(den_s);
    assign rem_n = ge ? rem_s - RemW'(den_s) : rem_s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j] && vin) begin
        rem_q[j] <= rem_n;
        quo_q[j] <= quo_s | QW'(ge);
        den_q[j] <= den_s;
        ctl_q[j] <= ctl_s;
      end
    end
  end

  assign in_ready_o = en[0];

  logic [QW-1:0]          quo_sat;
  logic signed [ImbW-1:0] imb_d;

  always_comb begin
    quo_sat = (quo_q[Steps-1] > QW'(OneQ14)) ? QW'(OneQ14) : quo_q[Steps-1];
    imb_d   = '0;
    if (ctl_q[Steps-1].ok) begin
      imb_d = ctl_q[Steps-1].negative ? -$signed(ImbW'(quo_sat))
                                       : $signed(ImbW'(quo_sat));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en[Steps]) begin
      ov_q <= v_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Steps] && v_q[Steps-1]) begin
      res_valid_q <= ctl_q[Steps-1].ok;
      imb_q       <= imb_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign result_valid_o = res_valid_q;
  assign imbalance_o    = imb_q;

endmodule

// ===== rtl/core/weighted_depth_imbalance.sv =====
// ----------------------------------------------------------------------------
// weighted_depth_imbalance
// Weighted order-book depth imbalance of one snapshot per word, in Q2.14.
// ----------------------------------------------------------------------------
// Usage:
// - in_i carries one book snapshot per word: five bid and five ask level
//   volumes and the two level presence masks. out_o returns one result word
//   per snapshot, in order: result_valid and the clamped Q2.14 imbalance.
// - The five Q1.16 level weights sit behind the APB port at byte addresses
//   0, 4, 8, 12 and 16; write them only while no word is in flight.
// - A word passes one multiply stage, one summing stage, one sign stage,
//   fifteen fully pipelined restoring divider stages (one quotient bit
//   each) and the output register on its way from accept to result.
// - One word is taken every cycle while the receiver is not stalling.
// - When the receiver stalls, words keep entering until every stage is
//   full; bubbles close up, nothing is dropped or repeated.
// - Reset empties the pipeline and loads the weights with exp(-k/2) values.
// ----------------------------------------------------------------------------
module weighted_depth_imbalance #(
  parameter int LEVELS = wdi_pkg::LevelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wdi_pkg::ApbAddrW-1:0]  paddr,
  input  logic [wdi_pkg::ApbDataW-1:0]  pwdata,
  output logic [wdi_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  wdi_in_if.sink                        in_i,
  wdi_out_if.source                     out_o
);
  import wdi_pkg::*;

  localparam int Lanes = (LEVELS < NumSlots) ? LEVELS : NumSlots;
  localparam int ProdW = VolW + WeightW;
  localparam int SumW  = ProdW + $clog2(Lanes);
  localparam int DenW  = SumW + 1;
  localparam int IdxW  = $clog2(NumSlots);

  // ---------------- weight registers ----------------
  logic [WeightW-1:0] w_q [NumSlots];
  logic [IdxW-1:0]    reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[IdxW+1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSlots; k++) begin
        w_q[k] <= WeightReset[k];
      end
    end else if (wr_en && (reg_idx < IdxW'(NumSlots))) begin
      w_q[reg_idx] <= pwdata[WeightW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < IdxW'(NumSlots)) begin
      prdata = ApbDataW'(w_q[reg_idx]);
    end
  end

  // ---------------- pipeline control ----------------
  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;
  logic div_ready;

  assign en_c       = ~vc_q | div_ready;
  assign en_b       = ~vb_q | en_c;
  assign en_a       = ~va_q | en_b;
  assign in_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_i.valid;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
    end
  end

  // ---------------- stage A: masked volume times weight ----------------
  logic [VolW-1:0]  bid_vol [NumSlots];
  logic [VolW-1:0]  ask_vol [NumSlots];
  logic [ProdW-1:0] prod_b_q [Lanes];
  logic [ProdW-1:0] prod_a_q [Lanes];
  logic             ok_a_q;

  always_comb begin
    bid_vol[0] = in_i.bid_volume_0;
    bid_vol[1] = in_i.bid_volume_1;
    bid_vol[2] = in_i.bid_volume_2;
    bid_vol[3] = in_i.bid_volume_3;
    bid_vol[4] = in_i.bid_volume_4;
    ask_vol[0] = in_i.ask_volume_0;
    ask_vol[1] = in_i.ask_volume_1;
    ask_vol[2] = in_i.ask_volume_2;
    ask_vol[3] = in_i.ask_volume_3;
    ask_vol[4] = in_i.ask_volume_4;
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    logic [VolW-1:0] bv, av;
    assign bv = in_i.bid_present_mask[k] ? bid_vol[k] : '0;
    assign av = in_i.ask_present_mask[k] ? ask_vol[k] : '0;

    always_ff @(posedge clk_i) begin
      if (en_a && in_i.valid) begin
        prod_b_q[k] <= ProdW'(w_q[k]) * ProdW'(bv);
        prod_a_q[k] <= ProdW'(w_q[k]) * ProdW'(av);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_i.valid) begin
      ok_a_q <= in_i.bid_present_mask[0] & in_i.ask_present_mask[0];
    end
  end

  // ---------------- stage B: side sums ----------------
  logic [SumW-1:0] pos_d, neg_d;
  logic [SumW-1:0] pos_q, neg_q;
  logic            ok_b_q;

  always_comb begin
    pos_d = '0;
    neg_d = '0;
    for (int k = 0; k < Lanes; k++) begin
      pos_d = pos_d + SumW'(prod_b_q[k]);
      neg_d = neg_d + SumW'(prod_a_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      pos_q  <= pos_d;
      neg_q  <= neg_d;
      ok_b_q <= ok_a_q;
    end
  end

  // ---------------- stage C: depth, sign and magnitude ----------------
  logic [DenW-1:0] den_d, mag_d;
  logic            negative;
  logic [DenW-1:0] den_q, mag_q;
  wdi_ctl_t        ctl_q;

  assign den_d    = DenW'(pos_q) + DenW'(neg_q);
  assign negative = neg_q > pos_q;
  assign mag_d    = negative ? DenW'(neg_q - pos_q) : DenW'(pos_q - neg_q);

  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      den_q          <= den_d;
      mag_q          <= mag_d;
      ctl_q.ok       <= ok_b_q & (den_d != '0);
      ctl_q.negative <= negative;
    end
  end

  // ---------------- divider and output register ----------------
  wdi_div_pipe #(
    .DenW (DenW)
  ) u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (vc_q),
    .in_ready_o     (div_ready),
    .mag_i          (mag_q),
    .den_i          (den_q),
    .ctl_i          (ctl_q),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_valid_o (out_o.result_valid),
    .imbalance_o    (out_o.imbalance)
  );

endmodule

// ===== rtl/core/wdi_checker.sv =====
// ----------------------------------------------------------------------------
// wdi_checker
// Port-level checks of the weighted depth imbalance block, bound to its top.
// ----------------------------------------------------------------------------
`include "weighted_depth_imbalance_defines.svh"

module wdi_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          result_valid,
  input logic signed [wdi_pkg::ImbW-1:0] imbalance
);
  import wdi_pkg::*;

  `WDI_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  `WDI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result_valid) && $stable(imbalance), "stalled result word changed")

  `WDI_ASSERT(a_invalid_zero, out_valid && !result_valid |-> imbalance == '0, "invalid result carries a nonzero imbalance")

  `WDI_ASSERT(a_range, out_valid |-> imbalance <= ImbW'(OneQ14) && imbalance >= -$signed(ImbW'(OneQ14)), "imbalance outside plus or minus one")

endmodule

bind weighted_depth_imbalance wdi_checker u_wdi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .result_valid (out_o.result_valid),
  .imbalance    (out_o.imbalance)
);
